>>> src/pprf_pkg.sv
package pprf_pkg;

    localparam int PEERS_DEF = 16;
    localparam int ADDR_W    = 48;
    localparam int NUM_W     = 32;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [NUM_W-1:0]  num;
    } entry_t;

endpackage

>>> src/pprf_if.sv
interface pprf_req_if
    import pprf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] sender_addr;
    logic [NUM_W-1:0]  msg_number;

    modport source (output valid, output op, output sender_addr, output msg_number,
                    input ready);
    modport sink (input valid, input op, input sender_addr, input msg_number,
                  output ready);
endinterface

interface pprf_rsp_if
    import pprf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [STATUS_W-1:0] status;
    logic                evicted;

    modport source (output valid, output accepted, output status, output evicted,
                    input ready);
    modport sink (input valid, input accepted, input status, input evicted,
                  output ready);
endinterface

>>> src/per_peer_replay_filter.sv
// Per-peer replay filter.
// req channel: one beat per item. op clears the table or checks a message
// number against the last number accepted from its sender address.
// rsp channel: exactly one beat per item with accepted, status and evicted.
// The table of PEERS entries sits in one synchronous memory with a registered
// read port; per-entry valid bits sit in flip-flops.
// A clear or a zero number goes straight to the finish state. A check walks
// every entry through the memory read port, one entry a cycle, to find the
// sender, the first free entry and the smallest stored address, and then
// finishes; in the finish state the result and the table update commit.
// Throughput: one item at a time; req.ready is high only while idle, and a
// result waiting on rsp does not block the next item from being taken.
// Reset empties the table at once (valid bits cleared), no sweep needed.
// When rsp stalls, the result holds on rsp; a finished item then waits
// before its table update and result are committed.
module per_peer_replay_filter
    import pprf_pkg::*;
#(
    parameter int PEERS = PEERS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pprf_req_if.sink   req,
    pprf_rsp_if.source rsp
);

    localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int CNT_W = $clog2(PEERS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    logic              match_reg, match_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic [NUM_W-1:0]  match_num_reg, match_num_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              min_reg, min_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [ADDR_W-1:0] min_addr_reg, min_addr_next;

    logic [PEERS-1:0] valid_reg, valid_next;

    entry_t           mem [PEERS];
    entry_t           rdata_reg;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ridx;
    logic             mem_we;
    logic [IDX_W-1:0] mem_widx;
    entry_t           mem_wdata;

    logic                out_valid_reg;
    logic                accepted_reg, accepted_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                evicted_reg, evicted_next;

    logic take;
    logic commit;

    assign req.ready    = (state_reg == ST_IDLE);
    assign take         = req.valid && req.ready;
    assign commit       = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);
    assign rsp.valid    = out_valid_reg;
    assign rsp.accepted = accepted_reg;
    assign rsp.status   = status_reg;
    assign rsp.evicted  = evicted_reg;

    assign mem_re   = (state_reg == ST_SCAN) && (issue_cnt_reg < CNT_W'(PEERS));
    assign mem_ridx = issue_cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ridx];
        end
    end

    // State control and scan: issue one read a cycle, evaluate the beat returned by the previous read.
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        match_num_next = match_num_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        min_next       = min_reg;
        min_idx_next   = min_idx_reg;
        min_addr_next  = min_addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    issue_cnt_next = '0;
                    match_next     = 1'b0;
                    free_next      = 1'b0;
                    min_next       = 1'b0;
                    if (req.op == OP_CLEAR || req.msg_number == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (mem_re)
                begin
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = mem_ridx;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg])
                    begin
                        if (!match_reg && rdata_reg.addr == addr_reg)
                        begin
                            match_next     = 1'b1;
                            match_idx_next = chk_idx_reg;
                            match_num_next = rdata_reg.num;
                        end
                        if (!min_reg || rdata_reg.addr < min_addr_reg)
                        begin
                            min_next      = 1'b1;
                            min_idx_next  = chk_idx_reg;
                            min_addr_next = rdata_reg.addr;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (chk_idx_reg == IDX_W'(PEERS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decide the result and the table update from the op, the number and the scan summary.
    always_comb
    begin
        valid_next     = valid_reg;
        mem_we         = 1'b0;
        mem_widx       = match_idx_reg;
        mem_wdata.addr = addr_reg;
        mem_wdata.num  = num_reg;
        accepted_next  = 1'b1;
        status_next    = STATUS_OK;
        evicted_next   = 1'b0;

        if (op_reg == OP_CLEAR)
        begin
            status_next = STATUS_CLEARED;
            if (commit)
            begin
                valid_next = '0;
            end
        end
        else if (num_reg == '0)
        begin
            accepted_next = 1'b0;
            status_next   = STATUS_ZERO;
        end
        else if (match_reg)
        begin
            if (num_reg <= match_num_reg)
            begin
                accepted_next = 1'b0;
                status_next   = STATUS_STALE;
            end
            else
            begin
                mem_we = commit;
            end
        end
        else if (free_reg)
        begin
            mem_widx = free_idx_reg;
            mem_we   = commit;
            if (commit)
            begin
                valid_next[free_idx_reg] = 1'b1;
            end
        end
        else
        begin
            // Full table: drop the smallest address, the new one included.
            evicted_next = 1'b1;
            mem_widx     = min_idx_reg;
            mem_we       = commit && min_reg && (min_addr_reg < addr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= req.op;
            addr_reg <= req.sender_addr;
            num_reg  <= req.msg_number;
        end
        if (commit)
        begin
            accepted_reg <= accepted_next;
            status_reg   <= status_next;
            evicted_reg  <= evicted_next;
        end
        issue_cnt_reg <= issue_cnt_next;
        chk_idx_reg   <= chk_idx_next;
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        match_num_reg <= match_num_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        min_reg       <= min_next;
        min_idx_reg   <= min_idx_next;
        min_addr_reg  <= min_addr_next;
    end

endmodule
